FILE: src/lpnal_pkg.sv
// shared types, codes and constants for the length-prefixed nal to annex-b converter
package lpnal_pkg;

    // width of the configuration register
    localparam int unsigned LEN_FIELD_W = 3;

    // smallest and largest length prefix size in bytes
    localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MIN = 3'd1;
    localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MAX = 3'd4;
    localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_RESET = 3'd4;

    // register index decoded from paddr
    localparam logic REG_LEN_FIELD = 1'b0;

    // annex-b start code
    localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    // error codes reported on the closing item
    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_ZERO_LEN      = 2'd1,
        ERR_TRUNC_LEN     = 2'd2,
        ERR_TRUNC_PAYLOAD = 2'd3
    } err_t;

    // parser phase
    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    // what the emitter has to produce for one input item
    typedef enum logic [1:0] {
        PLAN_NONE   = 2'd0,
        PLAN_STATUS = 2'd1,
        PLAN_DATA   = 2'd2,
        PLAN_START  = 2'd3
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t kind;
        logic [7:0] data;
        logic       done;
        err_t       err;
    } plan_t;

endpackage

FILE: src/length_prefixed_nal_to_annexb.sv
// top level of the length-prefixed nal to annex-b converter
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_in_byte, s_sample_end
//  m_        out        m_valid / m_ready  m_out_byte, m_byte_valid, m_run_last,
//                                          m_packet_done, m_error_code
//  apb       in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  one input byte per cycle while s_ready is high; an item passes the input register and
//  then the result register before its first result is on the result port
//  a length field that completes with a nonzero length, without the sample ending,
//  gives four start code items and holds the input while they leave the
//  result register
//  reset is synchronous on aresetn and returns the parser to the length field
//  a stall on m_ready backs up into s_ready without losing or repeating items
module length_prefixed_nal_to_annexb (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_sample_end,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_run_last,
    output logic        m_packet_done,
    output logic [1:0]  m_error_code,
    output logic        m_valid,
    input  logic        m_ready
);

    logic [lpnal_pkg::LEN_FIELD_W-1:0] len_field_bytes;
    logic                              plan_valid;
    logic                              plan_ready;
    lpnal_pkg::plan_t                  plan;

    // configuration register
    lpnal_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .len_field_bytes (len_field_bytes)
    );

    // input register and parser
    lpnal_parse u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .len_field_bytes (len_field_bytes),
        .s_in_byte       (s_in_byte),
        .s_sample_end    (s_sample_end),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .plan_valid      (plan_valid),
        .plan_ready      (plan_ready),
        .plan            (plan)
    );

    // result register and start code expansion
    lpnal_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .plan_valid    (plan_valid),
        .plan_ready    (plan_ready),
        .plan          (plan),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_run_last    (m_run_last),
        .m_packet_done (m_packet_done),
        .m_error_code  (m_error_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule

FILE: src/lpnal_cfg.sv
// apb register holding the length prefix size
module lpnal_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [lpnal_pkg::LEN_FIELD_W-1:0] len_field_bytes
);

    logic [lpnal_pkg::LEN_FIELD_W-1:0] len_field_reg;
    logic [lpnal_pkg::LEN_FIELD_W-1:0] len_field_next;
    logic                              wr_en;

    assign pready = 1'b1;

    // write strobe for the length field register
    assign wr_en = psel && penable && pwrite && pready
                   && (paddr[2] == lpnal_pkg::REG_LEN_FIELD);

    always_comb begin
        len_field_next = len_field_reg;
        if (wr_en) begin
            len_field_next = pwdata[lpnal_pkg::LEN_FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_field_reg <= lpnal_pkg::LEN_FIELD_RESET;
        end else begin
            len_field_reg <= len_field_next;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == lpnal_pkg::REG_LEN_FIELD) begin
            prdata = {{(32-lpnal_pkg::LEN_FIELD_W){1'b0}}, len_field_reg};
        end
    end

    assign len_field_bytes = len_field_reg;

endmodule

FILE: src/lpnal_parse.sv
// input register and length prefix parser producing one plan per item
module lpnal_parse (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [lpnal_pkg::LEN_FIELD_W-1:0]  len_field_bytes,
    input  logic [7:0]                         s_in_byte,
    input  logic                               s_sample_end,
    input  logic                               s_valid,
    output logic                               s_ready,
    output logic                               plan_valid,
    input  logic                               plan_ready,
    output lpnal_pkg::plan_t                   plan
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_end_reg;
    lpnal_pkg::phase_t     phase_reg;
    lpnal_pkg::phase_t     phase_next;
    logic [1:0]            prefix_reg;
    logic [1:0]            prefix_next;
    logic [31:0]           count_reg;
    logic [31:0]           count_next;
    logic                  in_take;
    logic                  plan_take;
    logic [2:0]            size;
    logic [2:0]            seen;
    logic [31:0]           shifted;
    logic [31:0]           count_dec;

    // input register handshake
    assign in_take   = s_valid && s_ready;
    assign plan_take = in_valid_reg && plan_ready;
    assign s_ready   = !in_valid_reg || plan_ready;
    assign plan_valid = in_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (plan_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= lpnal_pkg::PH_LENGTH;
            prefix_reg   <= '0;
            count_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            prefix_reg   <= prefix_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_sample_end;
        end
    end

    // clamp the prefix size to 1..4
    always_comb begin
        size = len_field_bytes;
        if (len_field_bytes < lpnal_pkg::LEN_FIELD_MIN) begin
            size = lpnal_pkg::LEN_FIELD_MIN;
        end else if (len_field_bytes > lpnal_pkg::LEN_FIELD_MAX) begin
            size = lpnal_pkg::LEN_FIELD_MAX;
        end
    end

    assign seen      = {1'b0, prefix_reg} + 3'd1;
    assign shifted   = {count_reg[23:0], in_byte_reg};
    assign count_dec = count_reg - 32'd1;

    // next state
    always_comb begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        count_next  = count_reg;
        if (plan_take) begin
            unique case (phase_reg)
                lpnal_pkg::PH_DISCARD: begin
                    if (in_end_reg) begin
                        phase_next = lpnal_pkg::PH_LENGTH;
                        count_next = '0;
                    end
                end
                lpnal_pkg::PH_PAYLOAD: begin
                    count_next = count_dec;
                    if (count_dec == '0 || in_end_reg) begin
                        phase_next  = lpnal_pkg::PH_LENGTH;
                        prefix_next = '0;
                        count_next  = '0;
                    end
                end
                lpnal_pkg::PH_LENGTH: begin
                    if (seen < size) begin
                        prefix_next = seen[1:0];
                        count_next  = shifted;
                        if (in_end_reg) begin
                            prefix_next = '0;
                            count_next  = '0;
                        end
                    end else begin
                        prefix_next = '0;
                        count_next  = shifted;
                        if (in_end_reg) begin
                            count_next = '0;
                        end else if (shifted == '0) begin
                            phase_next = lpnal_pkg::PH_DISCARD;
                        end else begin
                            phase_next = lpnal_pkg::PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    phase_next  = lpnal_pkg::PH_LENGTH;
                    prefix_next = '0;
                    count_next  = '0;
                end
            endcase
        end
    end

    // plan for the emitter
    always_comb begin
        plan.kind = lpnal_pkg::PLAN_NONE;
        plan.data = '0;
        plan.done = 1'b0;
        plan.err  = lpnal_pkg::ERR_NONE;
        unique case (phase_reg)
            lpnal_pkg::PH_DISCARD: begin
                if (in_end_reg) begin
                    plan.kind = lpnal_pkg::PLAN_STATUS;
                    plan.done = 1'b1;
                    plan.err  = lpnal_pkg::ERR_ZERO_LEN;
                end
            end
            lpnal_pkg::PH_PAYLOAD: begin
                plan.kind = lpnal_pkg::PLAN_DATA;
                plan.data = in_byte_reg;
                plan.done = in_end_reg;
                if (count_dec != '0 && in_end_reg) begin
                    plan.err = lpnal_pkg::ERR_TRUNC_PAYLOAD;
                end
            end
            lpnal_pkg::PH_LENGTH: begin
                if (seen < size) begin
                    if (in_end_reg) begin
                        plan.kind = lpnal_pkg::PLAN_STATUS;
                        plan.done = 1'b1;
                        plan.err  = lpnal_pkg::ERR_TRUNC_LEN;
                    end
                end else if (in_end_reg) begin
                    plan.kind = lpnal_pkg::PLAN_STATUS;
                    plan.done = 1'b1;
                    plan.err  = (shifted == '0) ? lpnal_pkg::ERR_ZERO_LEN
                                                : lpnal_pkg::ERR_TRUNC_PAYLOAD;
                end else if (shifted != '0) begin
                    plan.kind = lpnal_pkg::PLAN_START;
                end
            end
            default: begin
                plan.kind = lpnal_pkg::PLAN_NONE;
            end
        endcase
    end

endmodule

FILE: src/lpnal_emit.sv
// result register that expands start code plans into four items
module lpnal_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             plan_valid,
    output logic             plan_ready,
    input  lpnal_pkg::plan_t plan,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_run_last,
    output logic             m_packet_done,
    output logic [1:0]       m_error_code,
    output logic             m_valid,
    input  logic             m_ready
);

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [7:0]        byte_reg;
    logic [7:0]        byte_next;
    logic              bvalid_reg;
    logic              bvalid_next;
    logic              last_reg;
    logic              last_next;
    logic              done_reg;
    logic              done_next;
    lpnal_pkg::err_t   err_reg;
    lpnal_pkg::err_t   err_next;
    logic [1:0]        sc_left_reg;
    logic [1:0]        sc_left_next;
    logic [1:0]        sc_idx;
    logic              out_free;

    // output slot is free when empty or being taken this cycle
    assign out_free   = !m_valid_reg || m_ready;
    assign plan_ready = out_free && (sc_left_reg == 2'd0);
    assign sc_idx     = 2'd0 - sc_left_reg;

    // next result register contents
    always_comb begin
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        bvalid_next  = bvalid_reg;
        last_next    = last_reg;
        done_next    = done_reg;
        err_next     = err_reg;
        sc_left_next = sc_left_reg;
        if (out_free) begin
            m_valid_next = 1'b0;
            if (sc_left_reg != 2'd0) begin
                m_valid_next = 1'b1;
                byte_next    = lpnal_pkg::START_CODE[sc_idx];
                bvalid_next  = 1'b1;
                last_next    = (sc_left_reg == 2'd1);
                done_next    = 1'b0;
                err_next     = lpnal_pkg::ERR_NONE;
                sc_left_next = sc_left_reg - 2'd1;
            end else if (plan_valid) begin
                unique case (plan.kind)
                    lpnal_pkg::PLAN_NONE: begin
                        m_valid_next = 1'b0;
                    end
                    lpnal_pkg::PLAN_STATUS: begin
                        m_valid_next = 1'b1;
                        byte_next    = '0;
                        bvalid_next  = 1'b0;
                        last_next    = 1'b1;
                        done_next    = 1'b1;
                        err_next     = plan.err;
                    end
                    lpnal_pkg::PLAN_DATA: begin
                        m_valid_next = 1'b1;
                        byte_next    = plan.data;
                        bvalid_next  = 1'b1;
                        last_next    = 1'b1;
                        done_next    = plan.done;
                        err_next     = plan.err;
                    end
                    lpnal_pkg::PLAN_START: begin
                        m_valid_next = 1'b1;
                        byte_next    = lpnal_pkg::START_CODE[0];
                        bvalid_next  = 1'b1;
                        last_next    = 1'b0;
                        done_next    = 1'b0;
                        err_next     = lpnal_pkg::ERR_NONE;
                        sc_left_next = 2'd3;
                    end
                    default: begin
                        m_valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sc_left_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            sc_left_reg <= sc_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
        err_reg    <= err_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_byte_valid  = bvalid_reg;
    assign m_run_last    = last_reg;
    assign m_packet_done = done_reg;
    assign m_error_code  = err_reg;

    // a start code in progress always has an item on the output
    a_sc_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (sc_left_reg != 2'd0) |-> m_valid_reg)
        else $error("start code pending with empty output");

    // no new plan is taken while a start code is still being sent
    a_sc_blocks_plan: assert property (@(posedge aclk) disable iff (!aresetn)
        (sc_left_reg != 2'd0) |-> !plan_ready)
        else $error("plan accepted during start code");

    // a closing item is always the last item of its input
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && done_reg) |-> last_reg)
        else $error("packet_done without run_last");

    // errors appear only on the closing item
    a_err_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && err_reg != lpnal_pkg::ERR_NONE) |-> done_reg)
        else $error("error code on a non-closing item");

    // the start code sequence counts down one per taken item
    a_sc_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        (sc_left_reg != 2'd0 && m_ready) |=> (sc_left_reg == $past(sc_left_reg) - 2'd1))
        else $error("start code counter skipped");

endmodule

FILE: tb/sv/tb_length_prefixed_nal_to_annexb.sv
// self-checking testbench for the length-prefixed nal to annex-b converter
module tb_length_prefixed_nal_to_annexb;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 60;

    // one byte of the length-prefixed input stream
    typedef struct {
        logic [7:0] value;
        logic       eos;
    } src_byte_t;

    // one item of the annex-b output stream
    typedef struct {
        logic [7:0]        value;
        logic              vld;
        logic              run_end;
        logic              done;
        lpnal_pkg::err_t   err;
    } annexb_item_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [7:0]  s_in_byte;
    logic        s_sample_end;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_run_last;
    logic        m_packet_done;
    logic [1:0]  m_error_code;
    logic        m_valid;
    logic        m_ready;

    // bytes waiting for the driver and annex-b items still to come
    src_byte_t    sample_bytes [$];
    annexb_item_t annexb_expected [$];
    src_byte_t    next_byte;

    int unsigned items_queued;
    int unsigned items_accepted;
    int unsigned fails;
    int unsigned stall_cycles;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          s_taken;

    // converter state as the testbench sees it
    lpnal_pkg::phase_t ph;
    logic [1:0]        len_seen;
    logic [31:0]       len_count;
    logic [2:0]        len_cfg;

    length_prefixed_nal_to_annexb dut (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // register value to effective prefix size
    function automatic int unsigned field_size(input logic [2:0] cfg);
        if (cfg < lpnal_pkg::LEN_FIELD_MIN)
            return lpnal_pkg::LEN_FIELD_MIN;
        if (cfg > lpnal_pkg::LEN_FIELD_MAX)
            return lpnal_pkg::LEN_FIELD_MAX;
        return cfg;
    endfunction

    function automatic void restart_sample();
        ph        = lpnal_pkg::PH_LENGTH;
        len_seen  = '0;
        len_count = '0;
    endfunction

    function automatic void expect_item(input logic [7:0] value, input logic vld,
                                        input logic run_end, input logic done,
                                        input lpnal_pkg::err_t err);
        annexb_item_t it;
        it.value   = value;
        it.vld     = vld;
        it.run_end = run_end;
        it.done    = done;
        it.err     = err;
        annexb_expected.push_back(it);
    endfunction

    // annex-b items caused by one accepted input byte
    function automatic void convert_byte(input logic [7:0] b, input logic eos);
        int unsigned     size;
        int unsigned     nseen;
        lpnal_pkg::err_t err;
        size = field_size(len_cfg);
        case (ph)
            lpnal_pkg::PH_DISCARD: begin
                if (eos) begin
                    restart_sample();
                    expect_item(8'h00, 1'b0, 1'b1, 1'b1, lpnal_pkg::ERR_ZERO_LEN);
                end
            end
            lpnal_pkg::PH_PAYLOAD: begin
                err = lpnal_pkg::ERR_NONE;
                len_count = len_count - 32'd1;
                if (len_count == 0) begin
                    ph       = lpnal_pkg::PH_LENGTH;
                    len_seen = '0;
                end else if (eos) begin
                    err = lpnal_pkg::ERR_TRUNC_PAYLOAD;
                end
                expect_item(b, 1'b1, 1'b1, eos, err);
                if (eos)
                    restart_sample();
            end
            default: begin
                len_count = {len_count[23:0], b};
                nseen = len_seen + 1;
                if (nseen < size) begin
                    len_seen = nseen[1:0];
                    if (eos) begin
                        restart_sample();
                        expect_item(8'h00, 1'b0, 1'b1, 1'b1, lpnal_pkg::ERR_TRUNC_LEN);
                    end
                end else begin
                    len_seen = '0;
                    if (len_count == 0) begin
                        if (eos) begin
                            restart_sample();
                            expect_item(8'h00, 1'b0, 1'b1, 1'b1, lpnal_pkg::ERR_ZERO_LEN);
                        end else begin
                            ph = lpnal_pkg::PH_DISCARD;
                        end
                    end else if (eos) begin
                        restart_sample();
                        expect_item(8'h00, 1'b0, 1'b1, 1'b1,
                                    lpnal_pkg::ERR_TRUNC_PAYLOAD);
                    end else begin
                        ph = lpnal_pkg::PH_PAYLOAD;
                        for (int k = 0; k < 4; k++)
                            expect_item(lpnal_pkg::START_CODE[k], 1'b1, k == 3, 1'b0,
                                        lpnal_pkg::ERR_NONE);
                    end
                end
            end
        endcase
    endfunction

    function automatic void compare_field(input string fname, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $display("%0t %s expected %h actual %h", $time, fname, want, got);
            fails++;
        end
    endfunction

    // input driver: next byte once the previous one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (sample_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                next_byte = sample_bytes.pop_front();
                s_in_byte    <= next_byte.value;
                s_sample_end <= next_byte.eos;
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // monitor: predict on accepted bytes, check accepted results, watchdog
    always @(posedge aclk) begin
        annexb_item_t want;
        bit           m_taken;
        s_taken = aresetn && s_valid && s_ready;
        m_taken = aresetn && m_valid && m_ready;
        if (s_taken) begin
            items_accepted++;
            convert_byte(s_in_byte, s_sample_end);
        end
        if (m_taken) begin
            if (annexb_expected.size() == 0) begin
                $display("%0t unexpected item: expected none actual %h %b %b %b %0d", $time,
                         m_out_byte, m_byte_valid, m_run_last, m_packet_done, m_error_code);
                fails++;
            end else begin
                want = annexb_expected.pop_front();
                compare_field("out_byte", want.value, m_out_byte);
                compare_field("byte_valid", {7'd0, want.vld}, {7'd0, m_byte_valid});
                compare_field("run_last", {7'd0, want.run_end}, {7'd0, m_run_last});
                compare_field("packet_done", {7'd0, want.done}, {7'd0, m_packet_done});
                compare_field("error_code", {6'd0, want.err}, {6'd0, m_error_code});
            end
        end
        if (s_taken || m_taken)
            stall_cycles = 0;
        else if (items_accepted != items_queued || annexb_expected.size() != 0)
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("length_prefixed_nal_to_annexb: mismatch");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] value, input logic eos);
        src_byte_t one;
        one.value = value;
        one.eos   = eos;
        sample_bytes.push_back(one);
        items_queued++;
    endtask

    // sender holds off until all bytes are taken and every result is out
    task automatic wait_idle();
        while (items_accepted != items_queued || annexb_expected.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_len_field(input logic [2:0] value);
        wait_idle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lpnal_pkg::REG_LEN_FIELD, 2'b00};
        pwdata  <= {29'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        len_cfg = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one random sample: mostly well formed, some noise and some cut short
    task automatic queue_sample(input int unsigned fsize);
        src_byte_t   s [$];
        src_byte_t   one;
        int unsigned mix;
        int unsigned nal_len;
        int unsigned cut;
        mix = $urandom_range(0, 99);
        one.eos = 1'b0;
        if (mix < 12) begin
            repeat ($urandom_range(1, 12)) begin
                one.value = 8'($urandom);
                s.push_back(one);
            end
        end else begin
            repeat ($urandom_range(1, 3)) begin
                nal_len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
                for (int j = fsize - 1; j >= 0; j--) begin
                    one.value = 8'(nal_len >> (8 * j));
                    s.push_back(one);
                end
                repeat (nal_len) begin
                    one.value = 8'($urandom);
                    s.push_back(one);
                end
            end
            if (mix < 30) begin
                cut = $urandom_range(1, s.size());
                while (s.size() > cut)
                    void'(s.pop_back());
            end
        end
        s[s.size() - 1].eos = 1'b1;
        foreach (s[i])
            queue_byte(s[i].value, s[i].eos);
    endtask

    initial begin
        logic [2:0]  cfg_list [6];
        int unsigned tx_pct [3];
        int unsigned rx_pct [3];
        int unsigned phase_start;
        cfg_list = '{3'd1, 3'd4, 3'd2, 3'd6, 3'd3, 3'd0};
        tx_pct   = '{36, 65, 0};
        rx_pct   = '{65, 36, 0};
        aclk         = 1'b0;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_in_byte    = '0;
        s_sample_end = 1'b0;
        s_valid      = 1'b0;
        m_ready      = 1'b0;
        len_cfg      = lpnal_pkg::LEN_FIELD_RESET;
        restart_sample();
        tx_idle_pct  = tx_pct[0];
        rx_idle_pct  = rx_pct[0];
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // prefix size shrinks while two of four length bytes are in
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        write_len_field(3'd2);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hee, 1'b1);

        // one-byte prefix: normal end, zero length last, zero length mid-sample,
        // payload cut off
        write_len_field(3'd1);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'haa, 1'b0);
        queue_byte(8'hbb, 1'b0);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'h7f, 1'b1);
        queue_byte(8'h05, 1'b0);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b1);

        // two-byte prefix: sample ends inside the prefix, prefix ends the sample
        write_len_field(3'd2);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h05, 1'b1);

        // out-of-range sizes: zero acts as one, seven as four
        write_len_field(3'd0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b1);
        write_len_field(3'd7);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'hff, 1'b1);

        // random samples under three idle patterns, two sizes each
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 2; k++) begin
                write_len_field(cfg_list[2 * p + k]);
                tx_idle_pct = tx_pct[p];
                rx_idle_pct = rx_pct[p];
                phase_start = items_queued;
                while (items_queued - phase_start < PHASE_ITEMS)
                    queue_sample(field_size(len_cfg));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fails == 0)
            $display("length_prefixed_nal_to_annexb: match");
        else
            $display("length_prefixed_nal_to_annexb: mismatch");
        $finish;
    end

endmodule

FILE: files.f
src/lpnal_pkg.sv
src/lpnal_cfg.sv
src/lpnal_parse.sv
src/lpnal_emit.sv
src/length_prefixed_nal_to_annexb.sv
tb/sv/tb_length_prefixed_nal_to_annexb.sv
